>>> rtl/lzw_pkg.sv
`timescale 1ns / 1ps

package lzw_pkg;

    // Maximum count value of the output byte counter.
    localparam logic [30:0] COUNT_MAX = 31'h7FFF_FFFF;

    // Number of extra misses tolerated after the table is full.
    localparam int IDLE_MISSES = 1000;

    // First code handed out for a new string.
    localparam int FIRST_FREE = 256;

    // Control from the sequencer to the bit packer.
    typedef struct packed {
        logic        load;
        logic [15:0] code;
        logic        clear;
    } lzw_pack_cmd_t;

    // Status from the bit packer back to the sequencer.
    typedef struct packed {
        logic busy;
        logic halted;
    } lzw_pack_stat_t;

endpackage

>>> rtl/lzw_packer.sv
`timescale 1ns / 1ps

module lzw_packer
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = 14
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  lzw_pack_cmd_t  cmd,
    input  logic           final_code,
    input  logic           last_code,
    input  logic [30:0]    max_output_bytes,
    output lzw_pack_stat_t stat,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     code_byte,
    output logic           last_of_run,
    output logic           stream_done,
    output logic           overflow,
    output logic [30:0]    bytes_so_far
);

    localparam int CNT_W = 6;

    logic [31:0]      bits_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [30:0]      count_reg;
    logic             halted_reg;
    logic             final_reg;
    logic             lastc_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             lor_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic [30:0]      bsf_reg;

    logic [31:0]      ins_bits;
    logic [30:0]      cnt_inc;
    logic             will_more;
    logic             over;
    logic             drain;

    assign stat.busy   = valid_reg || (cnt_reg >= CNT_W'(8));
    assign stat.halted = halted_reg;

    assign ins_bits = 32'(cmd.code[CODE_BITS-1:0]) << (32 - CODE_BITS - 32'(cnt_reg));
    assign cnt_inc  = (count_reg < COUNT_MAX) ? count_reg + 31'd1 : count_reg;
    assign over     = cnt_inc > max_output_bytes;
    assign will_more = (cnt_reg - CNT_W'(8)) >= CNT_W'(8);

    // A byte leaves the shift register when the output register is free or being taken.
    assign drain = !cmd.clear && !cmd.load && (cnt_reg >= CNT_W'(8))
                   && (!valid_reg || out_ready);

    assign out_valid    = valid_reg;
    assign code_byte    = byte_reg;
    assign last_of_run  = lor_reg;
    assign stream_done  = done_reg;
    assign overflow     = ovf_reg;
    assign bytes_so_far = bsf_reg;

    // Shift register accepts a code and drains one byte per cycle while the output register is free or being taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg   <= '0;
            cnt_reg    <= '0;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            final_reg  <= 1'b0;
            lastc_reg  <= 1'b0;
            valid_reg  <= 1'b0;
            byte_reg   <= '0;
            lor_reg    <= 1'b0;
            done_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            bsf_reg    <= '0;
        end
        else
        begin
            if (drain)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cmd.clear)
            begin
                bits_reg   <= '0;
                cnt_reg    <= '0;
                count_reg  <= '0;
                halted_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                bits_reg  <= bits_reg | ins_bits;
                cnt_reg   <= cnt_reg + CNT_W'(CODE_BITS);
                final_reg <= final_code;
                lastc_reg <= last_code;
            end
            else if (drain)
            begin
                byte_reg  <= bits_reg[31:24];
                bsf_reg   <= cnt_inc;
                count_reg <= cnt_inc;
                if (over)
                begin
                    halted_reg <= 1'b1;
                    cnt_reg    <= '0;
                    bits_reg   <= '0;
                    lor_reg    <= 1'b1;
                    done_reg   <= 1'b1;
                    ovf_reg    <= 1'b1;
                end
                else
                begin
                    bits_reg <= bits_reg << 8;
                    cnt_reg <= cnt_reg - CNT_W'(8);
                    lor_reg <= lastc_reg && !will_more;
                    done_reg <= lastc_reg && final_reg && !will_more;
                    ovf_reg <= 1'b0;
                end
            end
        end
    end

endmodule

>>> rtl/lzw_compressor_14bit.sv
`timescale 1ns / 1ps
// An item is hashed, then the dictionary is read and compared once per probe; a miss then
// emits the current code, and each flush or end-of-stream code is emitted the same way.
// The block takes one item at a time. Reset (rst_n low, asynchronous) clears control state,
// then a clearing pass over all TABLE_ENTRIES entries empties the dictionary; the same pass
// runs on a first byte that is not also the last of its stream, and on a flush.

module lzw_compressor_14bit
    import lzw_pkg::*;
#(
    parameter int CODE_BITS     = 14,
    parameter int TABLE_ENTRIES = 18041
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_of_stream,
    input  logic        last_of_stream,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  code_byte,
    output logic        last_of_run,
    output logic        stream_done,
    output logic        overflow,
    output logic [30:0] bytes_so_far,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    localparam int IW = $clog2(TABLE_ENTRIES + 1);
    localparam int FW = CODE_BITS + 1;
    localparam int EW = 1 + FW + CODE_BITS + 8;
    localparam logic [FW-1:0] CODE_END   = FW'((1 << CODE_BITS) - 1);
    localparam logic [FW-1:0] CODE_CLEAR = FW'((1 << CODE_BITS) - 2);
    localparam logic [FW-1:0] CODE_TOP   = FW'((1 << CODE_BITS) - 3);
    localparam logic [FW-1:0] MISS_TOP   = FW'((1 << CODE_BITS) - 3 + IDLE_MISSES);
    localparam logic [IW-1:0] TE         = IW'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_HASH, S_READ, S_CMP, S_EMIT, S_E1, S_E2, S_E3, S_E4, S_WAIT
    } state_t;

    // Dictionary entry: valid, code, prefix, char; cleared by a sweep over all entries.
    logic [EW-1:0] dict_mem [TABLE_ENTRIES];
    logic [EW-1:0] rd_reg;
    logic          we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;

    state_t            state_reg;
    logic [IW-1:0]     pos_reg;
    logic [IW-1:0]     step_reg;
    logic [IW-1:0]     nprobe_reg;
    logic [IW-1:0]     clr_reg;
    logic [FW-1:0]     nfree_reg;
    logic [CODE_BITS-1:0] cur_reg;
    logic [7:0]        ch_reg;
    logic              last_reg;
    logic              active_reg;
    logic [30:0]       max_reg;
    logic [1:0]        seq_reg;
    logic [FW:0]       hraw_reg;

    lzw_pack_cmd_t  pcmd;
    lzw_pack_stat_t pstat;
    logic           pfinal;
    logic           plast;

    logic              hit;
    logic              empty;
    logic [IW-1:0]     pos_dec;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign empty = !rd_reg[EW-1];
    assign hit   = !empty && (rd_reg[CODE_BITS+7:8] == cur_reg) && (rd_reg[7:0] == ch_reg);
    assign pos_dec = (pos_reg >= step_reg) ? pos_reg - step_reg : pos_reg + TE - step_reg;

    // Dictionary memory with one write port and a separate registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            dict_mem[waddr] <= wdata;
        end
        rd_reg <= dict_mem[pos_reg];
    end

    lzw_packer #(.CODE_BITS(CODE_BITS)) u_pack (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (pcmd),
        .final_code       (pfinal),
        .last_code        (plast),
        .max_output_bytes (max_reg),
        .stat             (pstat),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .code_byte        (code_byte),
        .last_of_run      (last_of_run),
        .stream_done      (stream_done),
        .overflow         (overflow),
        .bytes_so_far     (bytes_so_far)
    );

    // Code chosen in each emit state.
    function automatic logic [FW-1:0] emit_code();
        logic [FW-1:0] c;
        c = '0;
        unique case (state_reg)
            S_EMIT: c = FW'(cur_reg);
            S_E1:   c = CODE_CLEAR;
            S_E2:   c = FW'(cur_reg);
            S_E3:   c = CODE_END;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic emit_last();
        logic r;
        r = 1'b0;
        unique case (state_reg)
            S_EMIT: r = !last_reg && (seq_reg == 2'd0);
            S_E1:   r = !last_reg;
            S_E4:   r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic emit_final();
        return state_reg == S_E4;
    endfunction

    // Combinational command decode for memory writes and packer clears and loads.
    always_comb
    begin
        we    = 1'b0;
        waddr = clr_reg;
        wdata = '0;
        pcmd  = '0;
        pfinal = 1'b0;
        plast  = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                we = 1'b1;
            end
            S_IDLE:
            begin
                pcmd.clear = in_valid && first_of_stream;
            end
            S_CMP:
            begin
                if (!hit && (empty || nprobe_reg == TE - IW'(1)) && nfree_reg <= CODE_TOP
                    && empty)
                begin
                    we    = 1'b1;
                    waddr = pos_reg;
                    wdata = {1'b1, nfree_reg, cur_reg, ch_reg};
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EMIT || state_reg == S_E1 || state_reg == S_E2
            || state_reg == S_E3 || state_reg == S_E4)
        begin
            if (!pstat.busy && !pstat.halted && seq_reg != 2'd3)
            begin
                pcmd.load = 1'b1;
                plast = 1'b0;
            end
        end
        pcmd.code = 16'(emit_code());
        plast  = emit_last();
        pfinal = emit_final();
    end

    // Sequencer: hash, probe loop, dictionary update, code emission.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            pos_reg    <= '0;
            step_reg   <= '0;
            nprobe_reg <= '0;
            nfree_reg  <= FW'(FIRST_FREE);
            cur_reg    <= '0;
            ch_reg     <= '0;
            last_reg   <= 1'b0;
            active_reg <= 1'b0;
            max_reg    <= COUNT_MAX;
            seq_reg    <= '0;
            hraw_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                max_reg <= cfg_data;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    if (clr_reg == TE - IW'(1))
                    begin
                        clr_reg   <= '0;
                        state_reg <= active_reg ? S_WAIT : S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + IW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ch_reg   <= data_byte;
                        last_reg <= last_of_stream;
                        hraw_reg <= (FW+1)'({data_byte, {(CODE_BITS-8){1'b0}}}) ^ (FW+1)'(cur_reg);
                        if (first_of_stream)
                        begin
                            active_reg <= 1'b1;
                            cur_reg    <= CODE_BITS'(data_byte);
                            nfree_reg  <= FW'(FIRST_FREE);
                            seq_reg    <= 2'd0;
                            state_reg  <= last_of_stream ? S_E2 : S_CLR;
                        end
                        else if (active_reg)
                        begin
                            state_reg <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    // One conditional subtract reduces the index below the table size.
                    if ((FW+1)'(hraw_reg) >= (FW+1)'(TABLE_ENTRIES))
                    begin
                        pos_reg  <= IW'(hraw_reg - (FW+1)'(TABLE_ENTRIES));
                        step_reg <= (hraw_reg == (FW+1)'(TABLE_ENTRIES)) ? IW'(1)
                                    : TE - IW'(hraw_reg - (FW+1)'(TABLE_ENTRIES));
                    end
                    else
                    begin
                        pos_reg  <= IW'(hraw_reg);
                        step_reg <= (hraw_reg == '0) ? IW'(1) : TE - IW'(hraw_reg);
                    end
                    nprobe_reg <= '0;
                    state_reg  <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (hit)
                    begin
                        cur_reg   <= rd_reg[2*CODE_BITS+7:CODE_BITS+8];
                        state_reg <= last_reg ? S_E2 : S_WAIT;
                        seq_reg   <= 2'd0;
                    end
                    else if (empty || nprobe_reg == TE - IW'(1))
                    begin
                        seq_reg <= 2'd0;
                        if (nfree_reg <= CODE_TOP || nfree_reg <= MISS_TOP)
                        begin
                            nfree_reg <= nfree_reg + FW'(1);
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                            seq_reg   <= 2'd1;
                        end
                    end
                    else
                    begin
                        pos_reg    <= pos_dec;
                        nprobe_reg <= nprobe_reg + IW'(1);
                        state_reg  <= S_READ;
                    end
                end
                S_EMIT:
                begin
                    if (pstat.halted)
                    begin
                        state_reg <= S_WAIT;
                        active_reg <= 1'b0;
                    end
                    else if (!pstat.busy)
                    begin
                        cur_reg <= CODE_BITS'(ch_reg);
                        if (seq_reg == 2'd1)
                        begin
                            state_reg <= S_E1;
                        end
                        else
                        begin
                            state_reg <= last_reg ? S_E2 : S_WAIT;
                        end
                    end
                end
                S_E1:
                begin
                    if (pstat.halted)
                    begin
                        state_reg <= S_WAIT;
                        active_reg <= 1'b0;
                    end
                    else if (!pstat.busy)
                    begin
                        nfree_reg <= FW'(FIRST_FREE);
                        state_reg <= S_CLR;
                    end
                end
                S_E2, S_E3, S_E4:
                begin
                    if (pstat.halted)
                    begin
                        state_reg  <= S_WAIT;
                        active_reg <= 1'b0;
                    end
                    else if (!pstat.busy)
                    begin
                        if (state_reg == S_E2)
                        begin
                            state_reg <= S_E3;
                        end
                        else if (state_reg == S_E3)
                        begin
                            state_reg <= S_E4;
                        end
                        else
                        begin
                            active_reg <= 1'b0;
                            state_reg  <= S_WAIT;
                        end
                    end
                end
                S_WAIT:
                begin
                    if (!pstat.busy)
                    begin
                        if (pstat.halted)
                        begin
                            active_reg <= 1'b0;
                        end
                        state_reg <= (last_reg && active_reg) ? S_E2 : S_IDLE;
                        if (last_reg)
                        begin
                            last_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The block never takes an item while the clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !in_ready)
        else $error("item accepted during clearing pass");

    // A hash position always stays inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (pos_reg < TE))
        else $error("probe position out of range");

    // The packer never loads a code while bytes are still draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        pcmd.load |-> !pstat.busy)
        else $error("code loaded while packer busy");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import lzw_pkg::*;
();

    localparam int CODE_W     = 14;
    localparam int SLOTS      = 18041;
    localparam int CODE_END   = (1 << CODE_W) - 1;
    localparam int CODE_TOP   = CODE_END - 2;
    localparam int CODE_FLUSH = CODE_END - 1;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } src_item_t;

    typedef struct {
        logic [7:0]  code;
        logic        last_run;
        logic        done;
        logic        ovf;
        logic [30:0] count;
    } code_item_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        first_of_stream;
    logic        last_of_stream;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  code_byte;
    logic        last_of_run;
    logic        stream_done;
    logic        overflow;
    logic [30:0] bytes_so_far;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [30:0] cfg_data;

    lzw_compressor_14bit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .first_of_stream (first_of_stream),
        .last_of_stream  (last_of_stream),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .code_byte       (code_byte),
        .last_of_run     (last_of_run),
        .stream_done     (stream_done),
        .overflow        (overflow),
        .bytes_so_far    (bytes_so_far),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    src_item_t  pending_src[$];
    code_item_t expected_codes[$];
    src_item_t  cur_src;
    int         error_count;
    int         cycle_count;
    bit         in_taken;
    bit         hold_src;
    bit         no_idle;
    int         src_gap;
    int         sink_gap;

    // Compressor state mirrored by the predictor.
    bit          dict_used[SLOTS];
    int unsigned dict_code[SLOTS];
    int unsigned dict_prefix[SLOTS];
    logic [7:0]  dict_char[SLOTS];
    int unsigned limit_bytes;
    int unsigned free_code;
    int unsigned cur_string;
    int unsigned bit_buf;
    int unsigned bit_cnt;
    int unsigned byte_count;
    bit          stream_active;
    bit          halted;
    int          step_results;

    // Clock generation.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("ERROR at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    endtask

    function automatic int unsigned find_slot(input int unsigned prefix, input int unsigned ch);
        int unsigned pos;
        int unsigned stride;
        pos = ((ch << (CODE_W - 8)) ^ prefix) % SLOTS;
        stride = (pos == 0) ? 1 : SLOTS - pos;
        for (int n = 0; n < SLOTS; n++) begin
            if (!dict_used[pos])
                return pos;
            if (dict_prefix[pos] == prefix && dict_char[pos] == ch[7:0])
                return pos;
            pos = (pos >= stride) ? pos - stride : pos + SLOTS - stride;
        end
        return SLOTS;
    endfunction

    function automatic void clear_dictionary();
        for (int i = 0; i < SLOTS; i++)
            dict_used[i] = 1'b0;
    endfunction

    // One packed output byte; going over the limit aborts the stream.
    function automatic void emit_byte(input int unsigned b);
        code_item_t e;
        if (byte_count < 32'h7FFF_FFFF)
            byte_count++;
        e.code = b[7:0];
        e.last_run = 1'b0;
        e.done = 1'b0;
        e.ovf = 1'b0;
        e.count = byte_count[30:0];
        if (byte_count > limit_bytes) begin
            e.done = 1'b1;
            e.ovf = 1'b1;
            stream_active = 1'b0;
            halted = 1'b1;
        end
        expected_codes.push_back(e);
        step_results++;
    endfunction

    function automatic void emit_code(input int unsigned code);
        if (halted)
            return;
        bit_buf |= (code & CODE_END) << (32 - CODE_W - bit_cnt);
        bit_cnt += CODE_W;
        while (bit_cnt >= 8 && !halted) begin
            emit_byte(bit_buf >> 24);
            bit_buf <<= 8;
            bit_cnt -= 8;
        end
    endfunction

    // Works out the packed bytes caused by one accepted source byte.
    function automatic void compress_byte(input src_item_t it);
        int unsigned slot;
        int unsigned ch;
        ch = 32'(it.data);
        halted = 1'b0;
        step_results = 0;
        if (it.first) begin
            clear_dictionary();
            free_code = FIRST_FREE;
            bit_buf = 0;
            bit_cnt = 0;
            byte_count = 0;
            stream_active = 1'b1;
            cur_string = ch;
        end else if (!stream_active) begin
            return;
        end else begin
            slot = find_slot(cur_string, ch);
            if (slot < SLOTS && dict_used[slot]) begin
                cur_string = dict_code[slot];
            end else if (free_code <= CODE_TOP) begin
                if (slot < SLOTS) begin
                    dict_used[slot] = 1'b1;
                    dict_code[slot] = free_code;
                    dict_prefix[slot] = cur_string;
                    dict_char[slot] = it.data;
                end
                free_code++;
                emit_code(cur_string);
                cur_string = ch;
            end else if (free_code > CODE_TOP + IDLE_MISSES) begin
                emit_code(cur_string);
                emit_code(CODE_FLUSH);
                clear_dictionary();
                cur_string = ch;
                free_code = FIRST_FREE;
            end else begin
                free_code++;
                emit_code(cur_string);
                cur_string = ch;
            end
        end
        if (it.last && !halted) begin
            emit_code(cur_string);
            emit_code(CODE_END);
            emit_code(0);
            if (!halted) begin
                stream_active = 1'b0;
                if (step_results > 0)
                    expected_codes[$].done = 1'b1;
            end
        end
        if (step_results > 0)
            expected_codes[$].last_run = 1'b1;
    endfunction

    // Accepted items are predicted first, then results are checked.
    always @(posedge clk) begin
        code_item_t e;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                limit_bytes = 32'(cfg_data);
            if (in_valid && in_ready) begin
                compress_byte(cur_src);
                in_taken = 1'b1;
            end
            if (out_valid && out_ready) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch("unexpected code_byte", int'(code_byte), -1);
                end else begin
                    e = expected_codes.pop_front();
                    if (code_byte !== e.code)
                        report_mismatch("code_byte", int'(code_byte), int'(e.code));
                    if (last_of_run !== e.last_run)
                        report_mismatch("last_of_run", int'(last_of_run), int'(e.last_run));
                    if (stream_done !== e.done)
                        report_mismatch("stream_done", int'(stream_done), int'(e.done));
                    if (overflow !== e.ovf)
                        report_mismatch("overflow", int'(overflow), int'(e.ovf));
                    if (bytes_so_far !== e.count)
                        report_mismatch("bytes_so_far", int'(bytes_so_far), int'(e.count));
                end
            end
        end
    end

    // Source driver with random bursts of idle cycles.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_taken)) begin
            in_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                in_valid <= 1'b0;
            end else if (pending_src.size() > 0 && !hold_src) begin
                cur_src = pending_src.pop_front();
                data_byte <= cur_src.data;
                first_of_stream <= cur_src.first;
                last_of_stream <= cur_src.last;
                in_valid <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 10);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Sink side stalls in bursts too.
    always @(negedge clk) begin
        if (rst_n) begin
            if (sink_gap > 0) begin
                sink_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] d, input bit f, input bit l);
        src_item_t it;
        it.data = d;
        it.first = f;
        it.last = l;
        pending_src.push_back(it);
    endtask

    // A stream of random bytes drawn from a window of the given width.
    task automatic add_stream(input int len, input int width, input bit ends);
        int base;
        base = $urandom_range(0, 256 - width);
        for (int i = 0; i < len; i++)
            add_byte(8'(base + $urandom_range(0, width - 1)), i == 0, ends && i == len - 1);
    endtask

    task automatic wait_idle();
        wait (pending_src.size() == 0 && !in_valid && expected_codes.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [30:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        first_of_stream = 1'b0;
        last_of_stream = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        in_taken = 1'b0;
        hold_src = 1'b0;
        no_idle = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        limit_bytes = 32'(COUNT_MAX);
        free_code = FIRST_FREE;
        cur_string = 0;
        bit_buf = 0;
        bit_cnt = 0;
        byte_count = 0;
        stream_active = 1'b0;
        clear_dictionary();
        repeat (10) @(posedge clk);
        rst_n = 1'b1;

        write_limit(COUNT_MAX);

        // Directed: stray byte, single-byte streams, extremes, repeats, restart.
        add_byte(8'h5A, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b1);
        add_byte(8'hFF, 1'b1, 1'b1);
        add_byte(8'hA5, 1'b0, 1'b1);
        add_byte(8'h41, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
            add_byte(8'h41, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1);
        wait_idle();

        // Abort on the very first byte, then bytes after the abort are ignored.
        write_limit(31'd0);
        add_byte(8'h12, 1'b1, 1'b1);
        add_byte(8'h34, 1'b0, 1'b0);
        wait_idle();
        write_limit(31'd3);
        add_stream(10, 256, 1'b1);
        add_byte(8'h77, 1'b0, 1'b1);
        wait_idle();

        // Random streams under several limits.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_limit(COUNT_MAX);
                1: write_limit(31'd12);
                2: write_limit(31'd40);
                default: write_limit(COUNT_MAX - 1);
            endcase
            for (int s = 0; s < 9; s++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    add_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                else if (kind == 1)
                    add_stream($urandom_range(2, 12), 256, 1'b0);
                else
                    add_stream($urandom_range(1, 20), (kind < 5) ? 3 : 256, 1'b1);
                if (phase == 0 && s == 4) begin
                    // Hold the source until every byte has come out.
                    hold_src = 1'b1;
                    wait (expected_codes.size() == 0 && !in_valid);
                    hold_src = 1'b0;
                end
            end
            wait_idle();
        end

        // One longer stream of random bytes.
        write_limit(COUNT_MAX);
        add_stream(40, 256, 1'b1);
        wait_idle();

        // Last part with no idling on either side.
        no_idle = 1'b1;
        sink_gap = 0;
        src_gap = 0;
        for (int s = 0; s < 5; s++)
            add_stream($urandom_range(5, 15), 4, 1'b1);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
